// ===== rtl/ilpm_pkg.sv =====
// Shared types, codes and action-word packing for the interval route table builder.
// No dependencies; every other file uses it through scoped names.
`timescale 1ns / 1ps

package ilpm_pkg;

   // operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

   // slot kinds
   localparam logic [1:0] KIND_EMPTY    = 2'd0;
   localparam logic [1:0] KIND_DEFAULT  = 2'd1;
   localparam logic [1:0] KIND_BOUNDARY = 2'd2;

   localparam logic [5:0]  MAX_PREFIX_LEN = 6'd32;
   localparam logic [29:0] EMPTY_LOW      = 30'h0070_0000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] route_key;
      logic [5:0]  prefix_len;
      logic [15:0] next_hop;
      logic [2:0]  precedence;
      logic [9:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] slot_key;
      logic [29:0] action_low;
      logic [17:0] action_high;
      logic [1:0]  slot_kind;
      logic [9:0]  entry_count;
   } rsp_type;

   // one stored boundary, 57 bits
   typedef struct packed {
      logic [31:0] route_key;
      logic [5:0]  prefix_len;
      logic [15:0] next_hop;
      logic [2:0]  precedence;
   } bound_type;

   // (32 - len) in bits 29:24, next hop in bits 15:0
   function automatic logic [29:0] low_word(input logic [5:0] len, input logic [15:0] hop);
      logic [5:0] span;
      begin
         span = MAX_PREFIX_LEN - len;
         return {span, 8'd0, hop};
      end
   endfunction

   // precedence in bits 17:15, route flag in bit 14
   function automatic logic [17:0] high_word(input logic [2:0] prec);
      return {prec, 1'b1, 14'd0};
   endfunction

endpackage

// ===== rtl/ilpm_bound_ram.sv =====
// Boundary store: simple dual-port synchronous RAM, one write and one registered read.
// Depends on ilpm_pkg for the entry type.
`timescale 1ns / 1ps

module ilpm_bound_ram #(
   parameter int DEPTH = 1023,
   parameter int AW    = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  ilpm_pkg::bound_type  wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output ilpm_pkg::bound_type  rd_data
);

   ilpm_pkg::bound_type mem [DEPTH];
   ilpm_pkg::bound_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/interval_lpm_table_builder.sv =====
// Interval route table builder top: request decode, insertion sequencer, result register.
// Depends on ilpm_pkg and ilpm_bound_ram.
// Flow: clear, default, error, full, unused-opcode and non-boundary reads go straight to the
//   finish step; boundary reads pass through the read step; an add walks the shift step down
//   past each stored boundary with a larger key, then writes the new one.
// Throughput: one item at a time; the next is taken once the one before has left the
//   sequencer, set by the single RAM read/write pair walking one entry per cycle.
// Reset: synchronous; empties the list and the default, no RAM clearing pass needed.
`timescale 1ns / 1ps

module interval_lpm_table_builder #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ilpm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ilpm_pkg::rsp_type rsp_data
);

   localparam int MAX_BOUNDS = TABLE_SLOTS - 1;
   localparam int AW = $clog2(MAX_BOUNDS);
   localparam int CW = $clog2(TABLE_SLOTS);
   localparam int XW = ((CW > 10) ? CW : 10) + 2;

   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BOUNDS);
   localparam logic [XW-1:0] SLOTS_X   = XW'(TABLE_SLOTS);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SHIFT  = 5'b00010,
      ST_PLACE  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                def_present_ff, def_present_in;
   logic [15:0]         def_hop_ff, def_hop_in;
   logic [2:0]          def_prec_ff, def_prec_in;
   ilpm_pkg::bound_type item_ff, item_in;
   ilpm_pkg::rsp_type   res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ilpm_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   ilpm_pkg::bound_type ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   ilpm_pkg::bound_type ram_rd_data;

   logic                req_xfer;
   logic [XW-1:0]       slot_x;
   logic [XW-1:0]       pos_sum;
   logic                slot_in_table;
   logic                slot_bound;
   logic                slot_default;
   logic                rsp_free;

   ilpm_bound_ram #(
      .DEPTH (MAX_BOUNDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Boundaries occupy the top slots: slot s holds entry s + total - TABLE_SLOTS.
   assign slot_x        = XW'(req_data.slot_index);
   assign pos_sum       = slot_x + XW'(total_ff);
   assign slot_in_table = (slot_x < SLOTS_X);
   assign slot_bound    = slot_in_table && (pos_sum >= SLOTS_X);
   assign slot_default  = slot_in_table && def_present_ff && (pos_sum + XW'(1) == SLOTS_X);

   always_comb begin
      state_in       = state_ff;
      total_in       = total_ff;
      pos_in         = pos_ff;
      def_present_in = def_present_ff;
      def_hop_in     = def_hop_ff;
      def_prec_in    = def_prec_ff;
      item_in        = item_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = AW'(pos_ff);
      ram_wr_data    = item_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = AW'(total_ff - CW'(1));

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               item_in.route_key  = req_data.route_key;
               item_in.prefix_len = req_data.prefix_len;
               item_in.next_hop   = req_data.next_hop;
               item_in.precedence = req_data.precedence;
               res_in             = '0;
               state_in           = ST_FINISH;
               case (req_data.op)
                  ilpm_pkg::OP_CLEAR: begin
                     total_in       = '0;
                     def_present_in = 1'b0;
                     def_hop_in     = '0;
                     def_prec_in    = '0;
                  end
                  ilpm_pkg::OP_ADD: begin
                     if (req_data.prefix_len > ilpm_pkg::MAX_PREFIX_LEN) begin
                        res_in.status = ilpm_pkg::STATUS_BAD_LEN;
                     end else if (req_data.route_key == '0 && req_data.prefix_len == '0) begin
                        def_present_in = 1'b1;
                        def_hop_in     = req_data.next_hop;
                        def_prec_in    = req_data.precedence;
                     end else if (total_ff == MAX_COUNT) begin
                        res_in.status = ilpm_pkg::STATUS_FULL;
                     end else if (total_ff == '0) begin
                        pos_in   = '0;
                        state_in = ST_PLACE;
                     end else begin
                        // fetch the last entry; walk down from the tail
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(total_ff - CW'(1));
                        pos_in      = total_ff;
                        state_in    = ST_SHIFT;
                     end
                  end
                  ilpm_pkg::OP_READ: begin
                     res_in.action_low = ilpm_pkg::EMPTY_LOW;
                     if (slot_bound) begin
                        ram_rd_en        = 1'b1;
                        ram_rd_addr      = AW'(pos_sum - SLOTS_X);
                        res_in.slot_kind = ilpm_pkg::KIND_BOUNDARY;
                        state_in         = ST_READ;
                     end else if (slot_default) begin
                        res_in.slot_kind   = ilpm_pkg::KIND_DEFAULT;
                        res_in.action_low  = ilpm_pkg::low_word(6'd0, def_hop_ff);
                        res_in.action_high = ilpm_pkg::high_word(def_prec_ff);
                     end
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // read data is entry pos-1; move it up if its key is larger
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(pos_ff);
            if (ram_rd_data.route_key > item_ff.route_key) begin
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - CW'(1);
               if (pos_ff == CW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(pos_ff - CW'(2));
               end
            end else begin
               ram_wr_data = item_ff;
               total_in    = total_ff + CW'(1);
               state_in    = ST_FINISH;
            end
         end

         ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(pos_ff);
            ram_wr_data = item_ff;
            total_in    = total_ff + CW'(1);
            state_in    = ST_FINISH;
         end

         ST_READ: begin
            res_in.slot_key    = ram_rd_data.route_key;
            res_in.action_low  = ilpm_pkg::low_word(ram_rd_data.prefix_len,
                                                    ram_rd_data.next_hop);
            res_in.action_high = ilpm_pkg::high_word(ram_rd_data.precedence);
            state_in           = ST_FINISH;
         end

         ST_FINISH: begin
            // hold until the result register is free, then load it
            if (rsp_free) begin
               rsp_data_in             = res_ff;
               rsp_data_in.entry_count = 10'(total_ff);
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         total_ff       <= '0;
         def_present_ff <= 1'b0;
         def_hop_ff     <= '0;
         def_prec_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         total_ff       <= total_in;
         def_present_ff <= def_present_in;
         def_hop_ff     <= def_hop_in;
         def_prec_ff    <= def_prec_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // count never passes the list capacity
   assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAX_COUNT)
      else $error("boundary count above capacity");

   // the shift walk never runs below the bottom entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (pos_ff != '0))
      else $error("shift walk at entry zero");

   // placing the new boundary grows the list by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |=> (total_ff == $past(total_ff) + CW'(1)))
      else $error("place did not bump count");

   // RAM writes stay within the occupied region plus the new tail slot
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CW'(ram_wr_addr) <= total_ff))
      else $error("RAM write beyond list tail");

   // a new result only comes out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

endmodule
